>>> rtl/core/priority_interrupt_controller_top_macros.svh
// ---------------------------------------------------------------------------
// Interrupt controller assertion macros
// Shared assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pic_pkg.sv
// ---------------------------------------------------------------------------
// Interrupt controller package
// Word types, access kinds and fixed constants shared by the core.
// ---------------------------------------------------------------------------
package pic_pkg;

  localparam logic [2:0] KIND_STEP       = 3'd0;
  localparam logic [2:0] KIND_WR_ENABLE  = 3'd1;
  localparam logic [2:0] KIND_WR_FLAG    = 3'd2;
  localparam logic [2:0] KIND_RD_ENABLE  = 3'd3;
  localparam logic [2:0] KIND_RD_FLAG    = 3'd4;
  localparam logic [2:0] KIND_RAISE      = 3'd5;
  localparam logic [2:0] KIND_SET_MASTER = 3'd6;

  localparam int unsigned NUM_IRQ = 5;

  localparam logic [7:0] FLAG_READ_ONES = 8'hE0;
  localparam logic [4:0] FLAG_MASK      = 5'h1F;
  localparam logic [1:0] DELAY_NEEDED   = 2'd2;
  localparam logic [4:0] FLAGS_RESET    = 5'h01;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        cpu_halted;
    logic        halt_quirk;
    logic [15:0] cpu_pc;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        halt_cleared;
    logic        dispatch;
    logic [15:0] return_address;
    logic [15:0] next_pc;
  } result_t;

endpackage

>>> rtl/core/priority_interrupt_controller_top.sv
// ---------------------------------------------------------------------------
// Priority interrupt controller
// Interrupt enable/flag registers with master enable and vectored dispatch.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per bus access, flag raise, master enable
//   write or per-instruction step check, selected by in_kind.
//   Result channel (out_*): exactly one word per input word, in order:
//   read data, halt wake, dispatch flag, return address and next PC.
//   Flow: a word accepted into the input register is evaluated by the core and
//   captured in the result register, and stays on the out_ ports until taken.
//   Throughput: one word per cycle while results are taken, set by the single
//   evaluate step between the input register and the result register.
//   Stall: while out_ready is low the result holds; the input register still
//   takes one more word, then in_ready drops until the result is taken.
//   Reset: enable register zero, vblank flag pending, master enable on,
//   enable delay zero, both channels empty.
// ---------------------------------------------------------------------------
`include "priority_interrupt_controller_top_macros.svh"

module priority_interrupt_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data,
  input  logic        in_cpu_halted,
  input  logic        in_halt_quirk,
  input  logic [15:0] in_cpu_pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_halt_cleared,
  output logic        out_dispatch,
  output logic [15:0] out_return_address,
  output logic [15:0] out_next_pc
);

  pic_pkg::item_t   item_r;
  logic             item_valid_r;
  pic_pkg::result_t res;
  pic_pkg::result_t res_r;
  logic             res_valid_r;
  logic             advance;

  assign advance  = item_valid_r & (~res_valid_r | out_ready);
  assign in_ready = ~item_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= '{kind: in_kind, data: in_data, cpu_halted: in_cpu_halted,
                  halt_quirk: in_halt_quirk, cpu_pc: in_cpu_pc};
    end
  end

  pic_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res;
  end

  assign out_valid          = res_valid_r;
  assign out_read_data      = res_r.read_data;
  assign out_halt_cleared   = res_r.halt_cleared;
  assign out_dispatch       = res_r.dispatch;
  assign out_return_address = res_r.return_address;
  assign out_next_pc        = res_r.next_pc;

  `PIC_ASSERT_NEXT(a_res_held, res_valid_r && !out_ready, res_valid_r && $stable(res_r),
                   "result dropped while stalled")
  `PIC_ASSERT_NOW(a_no_overrun, item_valid_r && res_valid_r && !out_ready, !in_ready,
                  "input taken while both stages full")
  `PIC_ASSERT_NEXT(a_advance_fills, advance, res_valid_r, "evaluated word lost")

endmodule

>>> rtl/core/pic_core.sv
// ---------------------------------------------------------------------------
// Interrupt controller core
// Holds enable, flag, master enable and delay state; evaluates one word.
// ---------------------------------------------------------------------------
`include "priority_interrupt_controller_top_macros.svh"

module pic_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  pic_pkg::item_t   item,
  output pic_pkg::result_t result
);

  logic       master_en_r, master_en_nxt;
  logic [1:0] delay_r, delay_nxt;
  logic [7:0] enable_r, enable_nxt;
  logic [4:0] flags_r, flags_nxt;

  logic [4:0] fire;
  logic [2:0] fire_idx;
  logic [1:0] delay_inc;
  logic       woke;
  logic       taken;
  logic [15:0] ret_pc;

  assign fire      = enable_r[4:0] & flags_r & pic_pkg::FLAG_MASK;
  assign delay_inc = (delay_r < pic_pkg::DELAY_NEEDED) ? delay_r + 2'd1 : delay_r;

  always_comb begin
    fire_idx = 3'd0;
    for (int i = pic_pkg::NUM_IRQ - 1; i >= 0; i--) begin
      if (fire[i]) fire_idx = 3'(i);
    end
  end

  always_comb begin
    woke  = 1'b0;
    taken = 1'b0;
    if (item.kind == pic_pkg::KIND_STEP && fire != 5'd0) begin
      woke  = item.cpu_halted & ~item.halt_quirk;
      taken = master_en_r & (delay_inc >= pic_pkg::DELAY_NEEDED);
    end
  end

  assign ret_pc = woke ? item.cpu_pc + 16'd1 : item.cpu_pc;

  always_comb begin
    result.read_data      = 8'd0;
    result.halt_cleared   = woke;
    result.dispatch       = taken;
    result.return_address = ret_pc;
    result.next_pc        = taken ? {8'h00, 2'b01, fire_idx, 3'b000} : ret_pc;
    case (item.kind)
      pic_pkg::KIND_RD_ENABLE: result.read_data = enable_r;
      pic_pkg::KIND_RD_FLAG:   result.read_data = pic_pkg::FLAG_READ_ONES | {3'b000, flags_r};
      default:                 result.read_data = 8'd0;
    endcase
  end

  always_comb begin
    master_en_nxt = master_en_r;
    delay_nxt     = delay_r;
    enable_nxt    = enable_r;
    flags_nxt     = flags_r;
    case (item.kind)
      pic_pkg::KIND_STEP: begin
        delay_nxt = delay_inc;
        if (taken) begin
          flags_nxt     = flags_r & ~(5'd1 << fire_idx);
          master_en_nxt = 1'b0;
        end
      end
      pic_pkg::KIND_WR_ENABLE: enable_nxt = item.data;
      pic_pkg::KIND_WR_FLAG:   flags_nxt  = item.data[4:0];
      pic_pkg::KIND_RAISE:     flags_nxt  = flags_r | item.data[4:0];
      pic_pkg::KIND_SET_MASTER: begin
        if (!master_en_r) delay_nxt = 2'd0;
        master_en_nxt = item.data[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_en_r <= 1'b1;
      delay_r     <= 2'd0;
      enable_r    <= 8'd0;
      flags_r     <= pic_pkg::FLAGS_RESET;
    end else if (advance) begin
      master_en_r <= master_en_nxt;
      delay_r     <= delay_nxt;
      enable_r    <= enable_nxt;
      flags_r     <= flags_nxt;
    end
  end

  `PIC_ASSERT_NOW(a_delay_sat, 1'b1, delay_r != 2'd3, "delay counter past saturation")
  `PIC_ASSERT_NOW(a_disp_needs_ime, advance && taken,
                  master_en_r && delay_inc == pic_pkg::DELAY_NEEDED,
                  "dispatch without master enable")
  `PIC_ASSERT_NEXT(a_disp_clears_ime, advance && taken, !master_en_r,
                   "master enable kept after dispatch")
  `PIC_ASSERT_NEXT(a_disp_clears_flag, advance && taken, flags_r[$past(fire_idx)] == 1'b0,
                   "dispatched flag not cleared")

endmodule

>>> dv/priority_interrupt_controller_top_tb.sv
// ---------------------------------------------------------------------------
// Priority interrupt controller testbench
// Sends bus accesses, flag raises, master enable writes and step checks
// through the input channel with random idle gaps and a long result stall.
// A scoreboard predicts every result word from its own copy of the enable,
// flag and master enable state and checks the words in order, field by field.
// ---------------------------------------------------------------------------
module priority_interrupt_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  KIND_UNUSED      = 3'd7;
  localparam logic [15:0] IRQ_VECTOR_BASE  = 16'h0040;
  localparam logic [15:0] IRQ_VECTOR_STEP  = 16'd8;
  localparam int unsigned NUM_RANDOM_WORDS = 1623;
  localparam int unsigned HOLD_OFF_CYCLES  = 250;
  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned MAX_REPORTS      = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_data = '0;
  logic        in_cpu_halted = 1'b0;
  logic        in_halt_quirk = 1'b0;
  logic [15:0] in_cpu_pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_halt_cleared;
  logic        out_dispatch;
  logic [15:0] out_return_address;
  logic [15:0] out_next_pc;

  pic_pkg::item_t   word_q[$];
  pic_pkg::result_t irq_resp_q[$];

  // shadow interrupt state
  logic        ime = 1'b1;
  logic [1:0]  ime_delay = 2'd0;
  logic [7:0]  ie_reg = 8'h00;
  logic [4:0]  if_reg = pic_pkg::FLAGS_RESET;

  int unsigned tx_gap = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_burst = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        hold_off = 1'b0;

  priority_interrupt_controller_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_data            (in_data),
    .in_cpu_halted      (in_cpu_halted),
    .in_halt_quirk      (in_halt_quirk),
    .in_cpu_pc          (in_cpu_pc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_halt_cleared   (out_halt_cleared),
    .out_dispatch       (out_dispatch),
    .out_return_address (out_return_address),
    .out_next_pc        (out_next_pc)
  );

  always #5 clk = ~clk;

  function automatic pic_pkg::result_t irq_respond(pic_pkg::item_t w);
    pic_pkg::result_t r;
    logic [4:0]       fire;
    logic [2:0]       idx;
    r = '0;
    idx = 3'd0;
    r.return_address = w.cpu_pc;
    case (w.kind)
      pic_pkg::KIND_STEP: begin
        fire = ie_reg[4:0] & if_reg;
        if (ime_delay < pic_pkg::DELAY_NEEDED) ime_delay = ime_delay + 2'd1;
        if (fire != '0) begin
          if (w.cpu_halted && !w.halt_quirk) begin
            r.halt_cleared = 1'b1;
            r.return_address = w.cpu_pc + 16'd1;
          end
          if (ime && ime_delay >= pic_pkg::DELAY_NEEDED) begin
            while (idx < 3'd4 && !fire[idx]) idx = idx + 3'd1;
            if_reg[idx] = 1'b0;
            ime = 1'b0;
            r.dispatch = 1'b1;
          end
        end
      end
      pic_pkg::KIND_WR_ENABLE:  ie_reg = w.data;
      pic_pkg::KIND_WR_FLAG:    if_reg = w.data[4:0] & pic_pkg::FLAG_MASK;
      pic_pkg::KIND_RD_ENABLE:  r.read_data = ie_reg;
      pic_pkg::KIND_RD_FLAG:    r.read_data = pic_pkg::FLAG_READ_ONES | {3'b000, if_reg};
      pic_pkg::KIND_RAISE:      if_reg = (if_reg | w.data[4:0]) & pic_pkg::FLAG_MASK;
      pic_pkg::KIND_SET_MASTER: begin
        if (!ime) ime_delay = 2'd0;
        ime = w.data[0];
      end
      default: ;
    endcase
    r.next_pc = r.dispatch ? IRQ_VECTOR_BASE + 16'(idx) * IRQ_VECTOR_STEP : r.return_address;
    return r;
  endfunction

  function automatic int unsigned idle_len(inout int unsigned burst_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_word(logic [2:0] kind, logic [7:0] data, logic halted, logic quirk,
                           logic [15:0] pc);
    pic_pkg::item_t w;
    w.kind = kind;
    w.data = data;
    w.cpu_halted = halted;
    w.halt_quirk = quirk;
    w.cpu_pc = pc;
    word_q.push_back(w);
  endtask

  function automatic pic_pkg::item_t rand_word();
    pic_pkg::item_t w;
    int unsigned    r;
    r = $urandom_range(0, 99);
    w.data = 8'($urandom_range(0, 255));
    w.cpu_halted = 1'($urandom_range(0, 1));
    w.halt_quirk = ($urandom_range(0, 3) == 0);
    w.cpu_pc = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    if (r < 40)      w.kind = pic_pkg::KIND_STEP;
    else if (r < 52) w.kind = pic_pkg::KIND_RAISE;
    else if (r < 64) begin
      w.kind = pic_pkg::KIND_SET_MASTER;
      if ($urandom_range(0, 9) < 7) w.data[0] = 1'b1;
    end
    else if (r < 71) w.kind = pic_pkg::KIND_WR_ENABLE;
    else if (r < 78) w.kind = pic_pkg::KIND_WR_FLAG;
    else if (r < 86) w.kind = pic_pkg::KIND_RD_ENABLE;
    else if (r < 96) w.kind = pic_pkg::KIND_RD_FLAG;
    else             w.kind = KIND_UNUSED;
    return w;
  endfunction

  task automatic note_mismatch(string what, pic_pkg::result_t want, pic_pkg::result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s exp rd=%h hc=%b dis=%b ret=%h pc=%h act rd=%h hc=%b dis=%b ret=%h pc=%h",
               $realtime, what, want.read_data, want.halt_cleared, want.dispatch,
               want.return_address, want.next_pc, got.read_data, got.halt_cleared,
               got.dispatch, got.return_address, got.next_pc);
  endtask

  // input driver
  always @(posedge clk) begin : drive_words
    logic           nxt_valid;
    pic_pkg::item_t nxt_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_word = {in_kind, in_data, in_cpu_halted, in_halt_quirk, in_cpu_pc};
      if (in_valid && in_ready) begin
        irq_resp_q.push_back(irq_respond(nxt_word));
        words_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (word_q.size() > 0) begin
          nxt_word = word_q.pop_front();
          nxt_valid = 1'b1;
          tx_gap = idle_len(tx_burst);
        end
      end
      in_valid <= nxt_valid;
      in_kind <= nxt_word.kind;
      in_data <= nxt_word.data;
      in_cpu_halted <= nxt_word.cpu_halted;
      in_halt_quirk <= nxt_word.halt_quirk;
      in_cpu_pc <= nxt_word.cpu_pc;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_words
    pic_pkg::result_t got;
    pic_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_read_data, out_halt_cleared, out_dispatch, out_return_address, out_next_pc};
        if (irq_resp_q.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = irq_resp_q.pop_front();
          if (got.read_data !== want.read_data || got.halt_cleared !== want.halt_cleared ||
              got.dispatch !== want.dispatch || got.return_address !== want.return_address ||
              got.next_pc !== want.next_pc)
            note_mismatch("mismatch", want, got);
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) rx_gap = idle_len(rx_burst);
      end
    end
  end

  // long receiver stall to back up the pipeline
  initial begin
    wait (words_taken >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("priority_interrupt_controller_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    push_word(pic_pkg::KIND_RD_FLAG,    8'h00, 1'b0, 1'b0, 16'h0100);
    push_word(pic_pkg::KIND_RD_ENABLE,  8'hFF, 1'b1, 1'b1, 16'h0101);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b1, 1'b0, 16'h0000);
    push_word(pic_pkg::KIND_WR_ENABLE,  8'hFF, 1'b0, 1'b0, 16'h0102);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b1, 1'b0, 16'hFFFF);
    push_word(pic_pkg::KIND_WR_FLAG,    8'hFE, 1'b0, 1'b0, 16'h0103);
    push_word(pic_pkg::KIND_RD_FLAG,    8'h00, 1'b0, 1'b0, 16'h0104);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b1, 1'b1, 16'h1234);
    push_word(pic_pkg::KIND_SET_MASTER, 8'h01, 1'b0, 1'b0, 16'h2000);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b0, 1'b0, 16'h8000);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b0, 1'b0, 16'h8001);
    push_word(pic_pkg::KIND_SET_MASTER, 8'hFF, 1'b0, 1'b0, 16'h2001);
    push_word(pic_pkg::KIND_SET_MASTER, 8'hFE, 1'b0, 1'b0, 16'h2002);
    push_word(pic_pkg::KIND_SET_MASTER, 8'h01, 1'b0, 1'b0, 16'h2003);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b1, 1'b0, 16'h7FFF);
    push_word(pic_pkg::KIND_STEP,       8'hFF, 1'b0, 1'b1, 16'hAAAA);
    push_word(pic_pkg::KIND_RAISE,      8'hE0, 1'b0, 1'b0, 16'h5555);
    push_word(pic_pkg::KIND_SET_MASTER, 8'h01, 1'b0, 1'b0, 16'h2004);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b0, 1'b0, 16'h3000);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b1, 1'b0, 16'h3001);
    push_word(pic_pkg::KIND_SET_MASTER, 8'h01, 1'b0, 1'b0, 16'h2005);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b0, 1'b0, 16'h4000);
    push_word(pic_pkg::KIND_STEP,       8'h00, 1'b0, 1'b0, 16'h4001);
    push_word(pic_pkg::KIND_RAISE,      8'h1F, 1'b0, 1'b0, 16'h0000);
    push_word(KIND_UNUSED,              8'hFF, 1'b1, 1'b1, 16'hFFFF);
    push_word(pic_pkg::KIND_WR_ENABLE,  8'h00, 1'b0, 1'b0, 16'h0105);
    push_word(pic_pkg::KIND_RD_ENABLE,  8'h00, 1'b0, 1'b0, 16'h0106);
    repeat (NUM_RANDOM_WORDS) word_q.push_back(rand_word());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (word_q.size() != 0 || in_valid || irq_resp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("priority_interrupt_controller_top_tb: clean");
    end else begin
      $display("priority_interrupt_controller_top_tb: errors");
    end
    $finish;
  end

endmodule
